// ===== design/bqd_pkg.sv =====
package bqd_pkg;

    // Fixed field widths of the sample and coefficient words.
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 32;
    localparam int CFG_IDX_W = 3;

    // Product of a coefficient and an input sample.
    localparam int FF_PROD_W = COEF_W + SAMPLE_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

    // Input command codes.
    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FF    = 5'b00010,
        ST_YCALC = 5'b00100,
        ST_FB    = 5'b01000,
        ST_UPD   = 5'b10000
    } t_state;

    // Status of one serial multiplier.
    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

// ===== design/bqd_serial_mul.sv =====
// Signed shift-add multiplier that consumes one multiplier bit per cycle.
// The partial sum shifts right; finished low product bits move serially
// into a low shift register. The most significant multiplier bit carries
// negative weight, so the last step subtracts the multiplicand.
module bqd_serial_mul import bqd_pkg::*; #(
    parameter int MCAND_W = 32,
    parameter int MPLR_W  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [MCAND_W-1:0]         i_mcand,
    input  logic signed [MPLR_W-1:0]          i_mplr,
    output t_mul_stat                         o_stat,
    output logic signed [MCAND_W+MPLR_W-1:0]  o_product
);

    localparam int CNT_W = $clog2(MPLR_W);

    logic                      r_busy;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [MCAND_W-1:0] r_mcand;
    logic [MPLR_W-1:0]         r_mplr;
    logic signed [MCAND_W+1:0] r_hi;
    logic [MPLR_W-1:0]         r_lo;

    logic                      w_last;
    logic signed [MCAND_W+1:0] w_ext;
    logic signed [MCAND_W+1:0] w_addend;
    logic signed [MCAND_W+1:0] n_sum;

    // One partial product per cycle; the sign bit step subtracts.
    assign w_last   = (r_cnt == CNT_W'(MPLR_W - 1));
    assign w_ext    = {{2{r_mcand[MCAND_W-1]}}, r_mcand};
    assign w_addend = !r_mplr[0] ? '0 : (w_last ? -w_ext : w_ext);
    assign n_sum    = r_hi + w_addend;

    // Step control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (w_last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Operand and product shift registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_mcand;
            r_mplr  <= i_mplr;
            r_hi    <= '0;
            r_lo    <= '0;
        end else if (r_busy) begin
            r_mplr <= {1'b0, r_mplr[MPLR_W-1:1]};
            r_hi   <= n_sum >>> 1;
            r_lo   <= {n_sum[0], r_lo[MPLR_W-1:1]};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_product   = {r_hi[MCAND_W-1:0], r_lo};

endmodule

// ===== design/biquad_iir_filter.sv =====
// Second-order IIR section in transposed direct form II on signed 16-bit
// samples, with five signed Q3.F coefficients written through a plain
// register port (b0, b1, b2, a1, a2 at indexes 0 to 4). The two delay
// states are saturating accumulators scaled by 2^F; the output is rounded
// half up and saturated to 16 bits. A filter transaction runs the three
// bit-serial feedforward multipliers (one sample bit per cycle), a step
// that registers the full-precision output, the two bit-serial feedback
// multipliers (one coefficient bit per cycle) and an update step. A clear
// transaction goes straight to the update step. Input is taken only
// while the sequencer is idle; a finished result waits in the output
// register while the next input is accepted, and a result is held back
// only if the previous one has not yet been taken.
module biquad_iir_filter import bqd_pkg::*; #(
    parameter int COEF_FRAC_BITS = 28,
    parameter int STATE_WIDTH    = 48
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [COEF_W-1:0]          i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_command,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_sample_out
);

    localparam int FB_PROD_W = STATE_WIDTH + COEF_W;
    localparam int SUM_W     = STATE_WIDTH + COEF_W + 2;
    localparam logic signed [SUM_W-1:0] ROUND_HALF =
        {{(SUM_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic signed [COEF_W-1:0] COEF_ONE =
        {{(COEF_W-1){1'b0}}, 1'b1} << COEF_FRAC_BITS;

    // Clamp a wide sum to the signed state range.
    function automatic logic signed [STATE_WIDTH-1:0] sat_state(
        input logic signed [SUM_W-1:0] v
    );
        logic [SUM_W-STATE_WIDTH:0] top_bits;
        top_bits = v[SUM_W-1:STATE_WIDTH-1];
        if (top_bits == '0 || top_bits == '1) begin
            return v[STATE_WIDTH-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(STATE_WIDTH-1){1'b0}}};
        end else begin
            return {1'b0, {(STATE_WIDTH-1){1'b1}}};
        end
    endfunction

    // Clamp a wide value to the signed sample range.
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [SUM_W-1:0] v
    );
        logic [SUM_W-SAMPLE_W:0] top_bits;
        top_bits = v[SUM_W-1:SAMPLE_W-1];
        if (top_bits == '0 || top_bits == '1) begin
            return v[SAMPLE_W-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    endfunction

    t_state                        r_state;
    logic                          r_clear;
    logic                          r_out_valid;
    logic signed [SAMPLE_W-1:0]    r_sample_out;
    logic signed [COEF_W-1:0]      r_coef_b0;
    logic signed [COEF_W-1:0]      r_coef_b1;
    logic signed [COEF_W-1:0]      r_coef_b2;
    logic signed [COEF_W-1:0]      r_coef_a1;
    logic signed [COEF_W-1:0]      r_coef_a2;
    logic signed [STATE_WIDTH-1:0] r_d1;
    logic signed [STATE_WIDTH-1:0] r_d2;
    logic signed [STATE_WIDTH-1:0] r_y;
    logic signed [SUM_W-1:0]       r_t1;

    logic                          w_in_acc;
    logic                          w_out_free;
    logic                          w_ff_start;
    logic                          w_fb_start;
    t_mul_stat                     w_ff0_stat;
    t_mul_stat                     w_ff1_stat;
    t_mul_stat                     w_ff2_stat;
    t_mul_stat                     w_fb1_stat;
    t_mul_stat                     w_fb2_stat;
    logic signed [FF_PROD_W-1:0]   w_p0;
    logic signed [FF_PROD_W-1:0]   w_p1;
    logic signed [FF_PROD_W-1:0]   w_p2;
    logic signed [FB_PROD_W-1:0]   w_q1;
    logic signed [FB_PROD_W-1:0]   w_q2;
    logic signed [SUM_W-1:0]       w_y_sum;
    logic signed [STATE_WIDTH-1:0] n_y;
    logic signed [SUM_W-1:0]       n_t1;
    logic signed [SUM_W-1:0]       w_r1_pre;
    logic signed [SUM_W-1:0]       w_r2_pre;
    logic signed [SUM_W-1:0]       w_r1;
    logic signed [SUM_W-1:0]       w_r2;
    logic signed [SUM_W-1:0]       w_y_pre;
    logic signed [SUM_W-1:0]       w_y_round;
    logic signed [STATE_WIDTH-1:0] n_d1;
    logic signed [STATE_WIDTH-1:0] n_d2;
    logic signed [SAMPLE_W-1:0]    n_sample_out;

    // Handshake qualifiers.
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_ff_start = w_in_acc && (i_command == CMD_FILTER);
    assign w_fb_start = (r_state == ST_YCALC);

    // Feedforward products b*x, one sample bit per cycle.
    bqd_serial_mul #(.MCAND_W(COEF_W), .MPLR_W(SAMPLE_W)) u_ff_b0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_ff_start),
        .i_mcand(r_coef_b0), .i_mplr(i_sample_in),
        .o_stat(w_ff0_stat), .o_product(w_p0)
    );
    bqd_serial_mul #(.MCAND_W(COEF_W), .MPLR_W(SAMPLE_W)) u_ff_b1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_ff_start),
        .i_mcand(r_coef_b1), .i_mplr(i_sample_in),
        .o_stat(w_ff1_stat), .o_product(w_p1)
    );
    bqd_serial_mul #(.MCAND_W(COEF_W), .MPLR_W(SAMPLE_W)) u_ff_b2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_ff_start),
        .i_mcand(r_coef_b2), .i_mplr(i_sample_in),
        .o_stat(w_ff2_stat), .o_product(w_p2)
    );

    // Full-precision output and the first partial state sum.
    assign w_y_sum = {{(SUM_W-FF_PROD_W){w_p0[FF_PROD_W-1]}}, w_p0}
                   + {{(SUM_W-STATE_WIDTH){r_d1[STATE_WIDTH-1]}}, r_d1};
    assign n_y     = sat_state(w_y_sum);
    assign n_t1    = {{(SUM_W-FF_PROD_W){w_p1[FF_PROD_W-1]}}, w_p1}
                   + {{(SUM_W-STATE_WIDTH){r_d2[STATE_WIDTH-1]}}, r_d2};

    // Feedback products a*y, one coefficient bit per cycle.
    bqd_serial_mul #(.MCAND_W(STATE_WIDTH), .MPLR_W(COEF_W)) u_fb_a1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_fb_start),
        .i_mcand(n_y), .i_mplr(r_coef_a1),
        .o_stat(w_fb1_stat), .o_product(w_q1)
    );
    bqd_serial_mul #(.MCAND_W(STATE_WIDTH), .MPLR_W(COEF_W)) u_fb_a2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_fb_start),
        .i_mcand(n_y), .i_mplr(r_coef_a2),
        .o_stat(w_fb2_stat), .o_product(w_q2)
    );

    // Round the feedback terms and the output half up, then saturate.
    assign w_r1_pre  = {{(SUM_W-FB_PROD_W){w_q1[FB_PROD_W-1]}}, w_q1} + ROUND_HALF;
    assign w_r2_pre  = {{(SUM_W-FB_PROD_W){w_q2[FB_PROD_W-1]}}, w_q2} + ROUND_HALF;
    assign w_r1      = w_r1_pre >>> COEF_FRAC_BITS;
    assign w_r2      = w_r2_pre >>> COEF_FRAC_BITS;
    assign n_d1      = sat_state(r_t1 - w_r1);
    assign n_d2      = sat_state({{(SUM_W-FF_PROD_W){w_p2[FF_PROD_W-1]}}, w_p2} - w_r2);
    assign w_y_pre   = {{(SUM_W-STATE_WIDTH){r_y[STATE_WIDTH-1]}}, r_y} + ROUND_HALF;
    assign w_y_round = w_y_pre >>> COEF_FRAC_BITS;
    assign n_sample_out = sat_sample(w_y_round);

    // Coefficient registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_b0 <= COEF_ONE;
            r_coef_b1 <= '0;
            r_coef_b2 <= '0;
            r_coef_a1 <= '0;
            r_coef_a2 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_B0:  r_coef_b0 <= i_cfg_data;
                REG_B1:  r_coef_b1 <= i_cfg_data;
                REG_B2:  r_coef_b2 <= i_cfg_data;
                REG_A1:  r_coef_a1 <= i_cfg_data;
                REG_A2:  r_coef_a2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer, delay states and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_clear     <= 1'b0;
            r_out_valid <= 1'b0;
            r_d1        <= '0;
            r_d2        <= '0;
        end else begin
            // The output flag rises on a finished update and falls when taken.
            if (r_state == ST_UPD && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_clear <= (i_command == CMD_CLEAR);
                        r_state <= (i_command == CMD_CLEAR) ? ST_UPD : ST_FF;
                    end
                end
                ST_FF: begin
                    if (w_ff0_stat.done) begin
                        r_state <= ST_YCALC;
                    end
                end
                ST_YCALC: begin
                    r_state <= ST_FB;
                end
                ST_FB: begin
                    if (w_fb1_stat.done) begin
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                        if (r_clear) begin
                            r_d1 <= '0;
                            r_d2 <= '0;
                        end else begin
                            r_d1 <= n_d1;
                            r_d2 <= n_d2;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath holding registers.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_YCALC) begin
            r_y  <= n_y;
            r_t1 <= n_t1;
        end
        if (r_state == ST_UPD && w_out_free) begin
            r_sample_out <= r_clear ? '0 : n_sample_out;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;

    // The three feedforward units and the two feedback units run in lockstep.
    a_ff_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ff1_stat == w_ff0_stat) && (w_ff2_stat == w_ff0_stat))
        else $error("feedforward multipliers out of step");

    a_fb_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fb2_stat == w_fb1_stat)
        else $error("feedback multipliers out of step");

    // A waiting result is never overwritten.
    a_upd_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD && r_out_valid && !i_out_ready) |=> r_state == ST_UPD)
        else $error("result written while output register is full");

    // A new result only comes from the update step.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_UPD)
        else $error("output valid raised outside the update step");

    // A clear transaction zeroes both delay states.
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD && r_clear && w_out_free) |=> (r_d1 == '0 && r_d2 == '0))
        else $error("clear did not zero the delay states");

endmodule
